@@ rtl/core/json_string_unescape_utf8_macros.svh @@
// assertion macros for the json string unescape block
// used by the top level only; bodies are empty when SYNTHESIS is defined
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`ifndef SYNTHESIS
`define JSU_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define JSU_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSU_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define JSU_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/jsu_pkg.sv @@
// shared types, codes and character helpers for the json string unescape block
// no dependencies
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;

  // results caused by one request: up to three bytes, or one done or error
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      kind;
    logic [1:0]      count;
  } group_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      v = {1'b0, b[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      8'h62:   v = 8'h08;
      8'h66:   v = 8'h0C;
      8'h6E:   v = 8'h0A;
      8'h72:   v = 8'h0D;
      8'h74:   v = 8'h09;
      default: v = b;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/jsu_decode.sv @@
// decode state machine: mode, hex digit count and gathered code point
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] in_byte,
  output group_t     res
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;

  logic [4:0]  digit;
  logic [15:0] cp_new;

  assign digit  = hex_value(in_byte);
  assign cp_new = {code_point[11:0], digit[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      code_point <= 16'd0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
    end
  end

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    res.bytes       = '0;
    res.kind        = KIND_BYTE;
    res.count       = 2'd0;
    if (mode == MODE_IDLE) begin
      if (!action && in_byte == CH_QUOTE) begin
        mode_next       = MODE_BODY;
        hex_count_next  = 2'd0;
        code_point_next = 16'd0;
      end
    end else if (action) begin
      res.kind        = KIND_ERROR;
      res.count       = 2'd1;
      mode_next       = MODE_IDLE;
      hex_count_next  = 2'd0;
      code_point_next = 16'd0;
    end else begin
      unique case (mode)
        MODE_BODY: begin
          if (in_byte == CH_QUOTE) begin
            res.kind        = KIND_DONE;
            res.count       = 2'd1;
            mode_next       = MODE_IDLE;
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
          end else if (in_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            res.bytes[0] = in_byte;
            res.count    = 2'd1;
          end
        end
        MODE_ESC: begin
          if (in_byte == CH_U) begin
            mode_next       = MODE_HEX;
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
          end else begin
            res.bytes[0] = escape_map(in_byte);
            res.count    = 2'd1;
            mode_next    = MODE_BODY;
          end
        end
        MODE_HEX: begin
          if (digit[4]) begin
            res.kind        = KIND_ERROR;
            res.count       = 2'd1;
            mode_next       = MODE_IDLE;
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
          end else if (hex_count == 2'd3) begin
            mode_next       = MODE_BODY;
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
            // utf-8 encoding of the completed code point
            if (cp_new[15:7] == 9'd0) begin
              res.bytes[0] = {1'b0, cp_new[6:0]};
              res.count    = 2'd1;
            end else if (cp_new[15:11] == 5'd0) begin
              res.bytes[0] = {3'b110, cp_new[10:6]};
              res.bytes[1] = {2'b10, cp_new[5:0]};
              res.count    = 2'd2;
            end else begin
              res.bytes[0] = {4'b1110, cp_new[15:12]};
              res.bytes[1] = {2'b10, cp_new[11:6]};
              res.bytes[2] = {2'b10, cp_new[5:0]};
              res.count    = 2'd3;
            end
          end else begin
            hex_count_next  = hex_count + 2'd1;
            code_point_next = cp_new;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/jsu_outbuf.sv @@
// result register: holds the results of one request and hands them out in order
// depends on jsu_pkg
module jsu_outbuf import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  group_t     res,
  output logic       can_take,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic       m_tlast
);

  group_t     grp;
  logic       valid;
  logic [1:0] idx;
  logic       take;

  assign m_tvalid = valid;
  assign m_tdata  = grp.bytes[idx];
  assign m_tuser  = grp.kind;
  assign m_tlast  = (idx == grp.count - 2'd1);
  assign take     = valid && m_tready;
  // a new group may enter as the last result of the old one leaves
  assign can_take = !valid || (m_tready && m_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (take) begin
      if (m_tlast) begin
        valid <= 1'b0;
        idx   <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp <= res;
  end

endmodule

@@ rtl/core/json_string_unescape_utf8.sv @@
// json string unescape block, text bytes in and utf-8 bytes out
// input channel s_*, result channel m_*; one text byte or end of text per
// request. the block waits for an opening quote, then copies plain bytes,
// resolves backslash escapes and turns each \u escape with four hex digits
// into one to three utf-8 bytes. a closing quote gives a done result, and a
// bad hex digit or end of text inside a string gives an error result.
// each request is decoded in the cycle it is taken; its results sit in the
// result register from the next cycle.
// throughput is one request per cycle while each causes at most one result and
// m_tready stays high; a \u escape that gives two or three bytes holds s_tready
// low while the result register hands them out, one per cycle with m_tready high.
// m_tlast marks the last result caused by a request.
// rst (synchronous) returns the decoder to idle and empties the result
// register. while m_tready is low the current result holds and s_tready
// stays low, so no request is taken until that result can leave.
// depends on jsu_pkg and json_string_unescape_utf8_macros.svh
`include "json_string_unescape_utf8_macros.svh"
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast
);

  group_t res;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (s_tuser),
    .in_byte (s_tdata),
    .res     (res)
  );

  jsu_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res.count != 2'd0),
    .res      (res),
    .can_take (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // done and error are always single results
  `JSU_ASSERT_IMP(a_multi_only_bytes, clk, rst, m_tvalid && !m_tlast,
    m_tuser == KIND_BYTE, "multi-byte group carries a non-byte kind")
  // a group that is not finished keeps presenting results
  `JSU_ASSERT_NXT(a_group_continues, clk, rst, m_tvalid && m_tready && !m_tlast,
    m_tvalid, "result group cut short")
  // input is only taken while a waiting result is leaving as the last of its group
  `JSU_ASSERT_IMP(a_ready_vs_pending, clk, rst, s_tready && m_tvalid,
    m_tready && m_tlast, "request taken over a pending result")

endmodule

@@ tb/json_string_unescape_utf8_test.sv @@
`timescale 1ns / 100ps
// self-checking bench for json_string_unescape_utf8: streams quoted json text
// and checks every utf-8 byte, done and error result; depends on jsu_pkg
module json_string_unescape_utf8_test import jsu_pkg::*;;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 50;   // per idling phase
  localparam logic [63:0] ESC_LETTERS = "bfnrt\"\\/";

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
  logic       s_tuser  = 1'b0;    // [0] action
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [7:0] out_byte
  logic [1:0] m_tuser;            // [1:0] kind
  logic       m_tlast;

  json_string_unescape_utf8 uut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  result_t     decoded_q[$];
  mode_t       dec_mode;
  logic [1:0]  hex_seen;
  logic [15:0] cp_acc;

  int send_idle_pct = 24;
  int recv_idle_pct = 62;
  int mismatches    = 0;
  int requests      = 0;
  int results_seen  = 0;
  int closes        = 0;
  int error_results = 0;
  int stall_cycles  = 0;

  // ---------------------------------------------------------------- decoder

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'h10;
  endfunction

  function automatic logic [7:0] unescaped(input logic [7:0] c);
    case (c)
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      default: return c;
    endcase
  endfunction

  task automatic reset_decoder();
    dec_mode = MODE_IDLE;
    hex_seen = 2'd0;
    cp_acc   = 16'h0000;
  endtask

  task automatic decode_request(input logic eot, input logic [7:0] c);
    result_t     res[$];
    logic [4:0]  nib;
    logic [15:0] cp;
    if (dec_mode == MODE_IDLE) begin
      if (!eot && c == CH_QUOTE) dec_mode = MODE_BODY;
    end else if (eot) begin
      res.insert(res.size(), {8'h00, KIND_ERROR, 1'b0});
      reset_decoder();
    end else begin
      case (dec_mode)
        MODE_BODY: begin
          if (c == CH_QUOTE) begin
            res.insert(res.size(), {8'h00, KIND_DONE, 1'b0});
            reset_decoder();
          end else if (c == CH_BACKSLASH) begin
            dec_mode = MODE_ESC;
          end else begin
            res.insert(res.size(), {c, KIND_BYTE, 1'b0});
          end
        end
        MODE_ESC: begin
          if (c == CH_U) begin
            dec_mode = MODE_HEX;
            hex_seen = 2'd0;
            cp_acc   = 16'h0000;
          end else begin
            res.insert(res.size(), {unescaped(c), KIND_BYTE, 1'b0});
            dec_mode = MODE_BODY;
          end
        end
        default: begin
          nib = hex_nibble(c);
          if (nib[4]) begin
            res.insert(res.size(), {8'h00, KIND_ERROR, 1'b0});
            reset_decoder();
          end else begin
            cp = {cp_acc[11:0], nib[3:0]};
            if (hex_seen == 2'd3) begin
              if (cp < 16'h0080) begin
                res.insert(res.size(), {cp[7:0], KIND_BYTE, 1'b0});
              end else if (cp < 16'h0800) begin
                res.insert(res.size(), {3'b110, cp[10:6], KIND_BYTE, 1'b0});
                res.insert(res.size(), {2'b10, cp[5:0], KIND_BYTE, 1'b0});
              end else begin
                res.insert(res.size(), {4'b1110, cp[15:12], KIND_BYTE, 1'b0});
                res.insert(res.size(), {2'b10, cp[11:6], KIND_BYTE, 1'b0});
                res.insert(res.size(), {2'b10, cp[5:0], KIND_BYTE, 1'b0});
              end
              dec_mode = MODE_BODY;
              hex_seen = 2'd0;
              cp_acc   = 16'h0000;
            end else begin
              cp_acc   = cp;
              hex_seen = hex_seen + 2'd1;
            end
          end
        end
      endcase
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) decoded_q.insert(decoded_q.size(), res[i]);
  endtask

  // ---------------------------------------------------------------- driving

  // entered and left just after a falling edge; valid stays high on exit
  task automatic send_request(input logic eot, input logic [7:0] c);
    logic counted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      s_tuser  = 1'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = eot;
    s_tdata  = c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // bytes ignored in idle do not count as traffic
    counted = dec_mode != MODE_IDLE || (!eot && c == CH_QUOTE);
    if (counted) requests++;
    decode_request(eot, c);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_tvalid = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
  endtask

  // sends the top n hex digits of cp, each in a random letter case
  task automatic send_hex_digits(input logic [15:0] cp, input int n);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int i = 3; i > 3 - n; i--) begin
      nib = cp[i*4 +: 4];
      if (nib < 4'd10) ch = "0" + nib;
      else ch = ($urandom_range(1) ? "A" : "a") + nib - 8'd10;
      send_request(1'b0, ch);
    end
  endtask

  task automatic send_unicode_escape(input logic [15:0] cp);
    send_request(1'b0, CH_BACKSLASH);
    send_request(1'b0, CH_U);
    send_hex_digits(cp, 4);
  endtask

  function automatic logic [15:0] random_code_point();
    logic [15:0] boundary_cps [8];
    boundary_cps = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                     16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF};
    case ($urandom_range(3))
      0:       return 16'($urandom_range(16'h007F));
      1:       return 16'($urandom_range(16'h07FF, 16'h0080));
      2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
      default: return boundary_cps[$urandom_range(7)];
    endcase
  endfunction

  task automatic send_bad_hex_digit();
    logic [7:0] ch;
    logic [4:0] nib;
    do begin
      ch  = 8'($urandom);
      nib = hex_nibble(ch);
    end while (!nib[4]);
    send_request(1'b0, ch);
  endtask

  // opening quote, a few random parts, then a close or a broken ending
  task automatic send_random_string();
    logic [7:0] ch;
    int parts;
    send_request(1'b0, CH_QUOTE);
    parts = $urandom_range(6);
    repeat (parts) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          do ch = 8'($urandom); while (ch == CH_QUOTE || ch == CH_BACKSLASH);
          send_request(1'b0, ch);
        end
        4, 5, 6: begin
          send_request(1'b0, CH_BACKSLASH);
          if ($urandom_range(1)) ch = ESC_LETTERS[$urandom_range(7)*8 +: 8];
          else do ch = 8'($urandom); while (ch == CH_U);
          send_request(1'b0, ch);
        end
        default: send_unicode_escape(random_code_point());
      endcase
    end
    case ($urandom_range(9))
      7: send_request(1'b1, 8'($urandom));
      8: begin
        // \u cut short by a bad digit or by end of text
        send_request(1'b0, CH_BACKSLASH);
        send_request(1'b0, CH_U);
        send_hex_digits(random_code_point(), $urandom_range(3));
        if ($urandom_range(1)) send_request(1'b1, 8'($urandom));
        else send_bad_hex_digit();
      end
      9: begin
        send_request(1'b0, CH_BACKSLASH);
        send_request(1'b1, 8'($urandom));
      end
      default: send_request(1'b0, CH_QUOTE);
    endcase
  endtask

  always @(negedge clk) m_tready <= $urandom_range(99) >= recv_idle_pct;

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser == KIND_DONE) closes++;
      if (m_tuser == KIND_ERROR) error_results++;
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: result byte %h kind %0d last %b with nothing expected",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, m_tdata);
        check_field("kind", 8'(want.kind), 8'(m_tuser));
        check_field("last", 8'(want.last), 8'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_idle_and_plain();
    send_request(1'b0, "a");         // ignored before the opening quote
    send_request(1'b1, 8'hFF);       // end of text in idle, no result
    send_request(1'b0, CH_QUOTE);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, CH_QUOTE);
  endtask

  // leaves the string open for the unicode test
  task automatic test_escapes();
    send_request(1'b0, CH_QUOTE);
    send_request(1'b0, CH_BACKSLASH);
    send_request(1'b0, "n");
    send_request(1'b0, CH_BACKSLASH);
    send_request(1'b0, 8'hFF);
  endtask

  task automatic test_unicode();
    send_unicode_escape(16'h0000);   // single zero byte
    send_unicode_escape(16'hDBAF);   // surrogate, plain three bytes
    send_request(1'b0, CH_QUOTE);
  endtask

  task automatic test_errors();
    send_request(1'b0, CH_QUOTE);
    send_request(1'b0, CH_BACKSLASH);
    send_request(1'b0, CH_U);
    send_request(1'b0, "G");
    send_request(1'b0, CH_QUOTE);
    send_request(1'b1, 8'h00);
    hold_until_drained();
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct);
    logic [7:0] ch;
    int start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = requests;
    while (requests - start < RANDOM_ITEMS) begin
      send_random_string();
      repeat ($urandom_range(2)) begin
        if ($urandom_range(1)) begin
          send_request(1'b1, 8'($urandom));
        end else begin
          do ch = 8'($urandom); while (ch == CH_QUOTE);
          send_request(1'b0, ch);
        end
      end
      if ($urandom_range(7) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    reset_decoder();
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_idle_and_plain();
    test_escapes();
    test_unicode();
    test_errors();
    test_random_traffic(24, 62);
    test_random_traffic(62, 24);
    test_random_traffic(0, 0);
    repeat (10) @(negedge clk);
    if (decoded_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, decoded_q.size());
    end
    $display("%0d text requests, %0d results (%0d strings closed, %0d errors)",
             requests, results_seen, closes, error_results);
    $display("escapes, 1-3 byte \\u code points, bad hex and end of text, 3 idle mixes");
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_outbuf.sv
rtl/core/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_test.sv
